// ===== hdl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/scbca_pkg.sv =====
`timescale 1ns / 1ps

package scbca_pkg;

    localparam int NUM_REGS   = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int REQ_W      = 16;
    localparam int POOL_ID_W  = 3;
    localparam int CELL_W     = 10;
    localparam int STATUS_W   = 3;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ALLOCATED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREED      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_POOLED = 3'd4;

    localparam logic [CFG_DATA_W-1:0] CLASS_SIZE_RESET [NUM_REGS] =
        '{13'd16, 13'd32, 13'd64, 13'd128, 13'd256};

    typedef struct packed {
        logic                  action;
        logic [REQ_W-1:0]      request_size;
        logic [POOL_ID_W-1:0]  free_pool;
        logic [CELL_W-1:0]     free_cell;
    } scbca_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [POOL_ID_W-1:0]  pool_id;
        logic [CELL_W-1:0]     cell_id;
    } scbca_out_t;

    // controller -> datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic decode;
        logic start_scan;
        logic rd_scan;
        logic eval;
        logic rd_free;
        logic wr_free;
    } scbca_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic is_free;
        logic decode_done;
        logic full;
        logic scan_done;
    } scbca_sts_t;

endpackage

// ===== hdl/scbca_ctrl.sv =====
`timescale 1ns / 1ps

module scbca_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  scbca_pkg::scbca_sts_t  sts,
    output scbca_pkg::scbca_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_DECODE  = 8'b0000_0100,
        S_START   = 8'b0000_1000,
        S_READ    = 8'b0001_0000,
        S_EVAL    = 8'b0010_0000,
        S_FREE_RD = 8'b0100_0000,
        S_FREE_WR = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                priority if (sts.decode_done)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.is_free)
                begin
                    state_next = S_FREE_RD;
                end
                else
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.start_scan = 1'b1;
                state_next     = sts.full ? S_IDLE : S_EVAL;
            end
            S_READ:
            begin
                cmd.rd_scan = 1'b1;
                state_next  = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = sts.scan_done ? S_IDLE : S_READ;
            end
            S_FREE_RD:
            begin
                cmd.rd_free = 1'b1;
                state_next  = S_FREE_WR;
            end
            S_FREE_WR:
            begin
                cmd.wr_free = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== hdl/scbca_datapath.sv =====
`timescale 1ns / 1ps

module scbca_datapath #(
    parameter int NUM_POOLS      = 5,
    parameter int CELLS_PER_POOL = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  scbca_pkg::scbca_cmd_t               cmd,
    output scbca_pkg::scbca_sts_t               sts,
    input  scbca_pkg::scbca_in_t                req,
    input  logic                                cfg_we,
    input  logic [scbca_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [scbca_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output logic                                done,
    output scbca_pkg::scbca_out_t               result
);

    localparam int POS_W     = ($clog2(CELLS_PER_POOL) > 3) ? $clog2(CELLS_PER_POOL) : 4;
    localparam int BYTE_AW   = POS_W - 3;
    localparam int POOL_W    = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
    localparam int AW        = POOL_W + BYTE_AW;
    localparam int DEPTH     = NUM_POOLS << BYTE_AW;
    localparam int MAP_BYTES = (CELLS_PER_POOL + 7) / 8;
    localparam int LAST_BITS = CELLS_PER_POOL % 8;
    localparam int CNT_W     = $clog2(CELLS_PER_POOL + 1);
    localparam int NREAD_W   = BYTE_AW + 1;
    localparam logic [7:0] LAST_MASK = 8'((1 << LAST_BITS) - 1);
    localparam logic [BYTE_AW-1:0] LAST_BYTE = BYTE_AW'(MAP_BYTES - 1);

    scbca_pkg::scbca_in_t    in_reg, in_next;
    logic [POOL_W-1:0]       pool_reg, pool_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [BYTE_AW-1:0]      cursor_reg, cursor_next;
    logic [2:0]              off_reg, off_next;
    logic                    first_reg, first_next;
    logic [NREAD_W-1:0]      nread_reg, nread_next;
    logic [AW-1:0]           clr_cnt_reg, clr_cnt_next;
    logic [scbca_pkg::CFG_DATA_W-1:0] class_size_reg [scbca_pkg::NUM_REGS];
    logic [scbca_pkg::CFG_DATA_W-1:0] class_size_next [scbca_pkg::NUM_REGS];
    logic [CNT_W-1:0]        used_cnt_reg [NUM_POOLS];
    logic [CNT_W-1:0]        used_cnt_next [NUM_POOLS];
    logic [POS_W-1:0]        scan_pos_reg [NUM_POOLS];
    logic [POS_W-1:0]        scan_pos_next [NUM_POOLS];
    logic                    done_reg, done_next;
    scbca_pkg::scbca_out_t   result_reg, result_next;

    // byte-wide used-bit map, one row of bytes per pool
    logic [7:0]              mem [DEPTH];
    logic [7:0]              rdata_reg;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [7:0]              wr_data;

    logic                    sel_found;
    logic [POOL_W-1:0]       sel_pool;
    logic                    free_ok;
    logic [CNT_W-1:0]        cur_cnt;
    logic [POS_W-1:0]        cur_scan;
    logic                    pool_full;
    logic [7:0]              valid_mask;
    logic [7:0]              start_mask;
    logic [7:0]              free_bits;
    logic                    hit;
    logic [2:0]              hit_bit;
    logic [POS_W-1:0]        hit_pos;
    logic                    give_up;
    logic [BYTE_AW-1:0]      cursor_inc;
    logic                    free_bit_set;

    // first pool whose cell size covers the request
    always_comb
    begin
        sel_found = 1'b0;
        sel_pool  = '0;
        for (int p = 0; p < NUM_POOLS; p++)
        begin
            if (!sel_found &&
                ({3'b000, class_size_reg[p]} >= in_reg.request_size))
            begin
                sel_found = 1'b1;
                sel_pool  = POOL_W'(p);
            end
        end
    end

    assign free_ok = (32'(in_reg.free_pool) < NUM_POOLS) &&
                     (32'(in_reg.free_cell) < CELLS_PER_POOL);

    assign cur_cnt   = used_cnt_reg[pool_reg];
    assign cur_scan  = scan_pos_reg[pool_reg];
    assign pool_full = (cur_cnt == CNT_W'(CELLS_PER_POOL));

    // last byte of a pool may be partly beyond the pool end
    assign valid_mask = ((LAST_BITS != 0) && (cursor_reg == LAST_BYTE)) ? LAST_MASK : 8'hFF;
    assign start_mask = first_reg ? (8'hFF << off_reg) : 8'hFF;
    assign free_bits  = ~rdata_reg & valid_mask & start_mask;
    assign hit        = |free_bits;

    always_comb
    begin
        hit_bit = '0;
        for (int i = 7; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                hit_bit = 3'(i);
            end
        end
    end

    assign hit_pos      = {cursor_reg, hit_bit};
    assign give_up      = !hit && (nread_reg == NREAD_W'(MAP_BYTES));
    assign cursor_inc   = (cursor_reg == LAST_BYTE) ? '0 : cursor_reg + 1'b1;
    assign free_bit_set = rdata_reg[pos_reg[2:0]];

    // memory port control
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = {pool_reg, cursor_reg};
        wr_en   = 1'b0;
        wr_addr = {pool_reg, cursor_reg};
        wr_data = rdata_reg | (8'b1 << hit_bit);
        priority if (cmd.start_scan)
        begin
            rd_en   = 1'b1;
            rd_addr = {pool_reg, cur_scan[POS_W-1:3]};
        end
        else if (cmd.rd_scan)
        begin
            rd_en = 1'b1;
        end
        else if (cmd.rd_free)
        begin
            rd_en   = 1'b1;
            rd_addr = {pool_reg, pos_reg[POS_W-1:3]};
        end
        else if (cmd.clear)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = 8'h00;
        end
        else if (cmd.eval)
        begin
            wr_en = hit;
        end
        else if (cmd.wr_free)
        begin
            wr_en   = free_bit_set;
            wr_addr = {pool_reg, pos_reg[POS_W-1:3]};
            wr_data = rdata_reg & ~(8'b1 << pos_reg[2:0]);
        end
        else
        begin
            rd_en = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        in_next         = in_reg;
        pool_next       = pool_reg;
        pos_next        = pos_reg;
        cursor_next     = cursor_reg;
        off_next        = off_reg;
        first_next      = first_reg;
        nread_next      = nread_reg;
        clr_cnt_next    = clr_cnt_reg;
        class_size_next = class_size_reg;
        used_cnt_next   = used_cnt_reg;
        scan_pos_next   = scan_pos_reg;
        done_next       = 1'b0;
        result_next     = result_reg;

        if (cfg_we && (32'(cfg_addr) < scbca_pkg::NUM_REGS))
        begin
            class_size_next[cfg_addr] = cfg_wdata;
        end

        if (cmd.clear)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end

        if (cmd.load)
        begin
            in_next = req;
        end

        if (cmd.decode)
        begin
            if (in_reg.action == scbca_pkg::ACT_FREE)
            begin
                pool_next = POOL_W'(in_reg.free_pool);
                pos_next  = POS_W'(in_reg.free_cell);
                if (!free_ok)
                begin
                    done_next   = 1'b1;
                    result_next = '{scbca_pkg::ST_NOT_POOLED, '0, '0};
                end
            end
            else
            begin
                pool_next = sel_pool;
                if (!sel_found)
                begin
                    done_next   = 1'b1;
                    result_next = '{scbca_pkg::ST_TOO_LARGE, '0, '0};
                end
            end
        end

        if (cmd.start_scan)
        begin
            cursor_next = cur_scan[POS_W-1:3];
            off_next    = cur_scan[2:0];
            first_next  = 1'b1;
            nread_next  = '0;
            if (pool_full)
            begin
                done_next   = 1'b1;
                result_next = '{scbca_pkg::ST_EXHAUSTED,
                                scbca_pkg::POOL_ID_W'(pool_reg), '0};
            end
        end

        if (cmd.eval)
        begin
            if (hit)
            begin
                used_cnt_next[pool_reg] = cur_cnt + 1'b1;
                scan_pos_next[pool_reg] = hit_pos;
                done_next   = 1'b1;
                result_next = '{scbca_pkg::ST_ALLOCATED,
                                scbca_pkg::POOL_ID_W'(pool_reg),
                                scbca_pkg::CELL_W'(hit_pos)};
            end
            else if (give_up)
            begin
                done_next   = 1'b1;
                result_next = '{scbca_pkg::ST_EXHAUSTED,
                                scbca_pkg::POOL_ID_W'(pool_reg), '0};
            end
            else
            begin
                cursor_next = cursor_inc;
                first_next  = 1'b0;
                nread_next  = nread_reg + 1'b1;
            end
        end

        if (cmd.wr_free)
        begin
            if (free_bit_set && (cur_cnt != '0))
            begin
                used_cnt_next[pool_reg] = cur_cnt - 1'b1;
            end
            done_next   = 1'b1;
            result_next = '{scbca_pkg::ST_FREED, '0, '0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
            for (int i = 0; i < scbca_pkg::NUM_REGS; i++)
            begin
                class_size_reg[i] <= scbca_pkg::CLASS_SIZE_RESET[i];
            end
            for (int p = 0; p < NUM_POOLS; p++)
            begin
                used_cnt_reg[p] <= '0;
                scan_pos_reg[p] <= '0;
            end
        end
        else
        begin
            clr_cnt_reg    <= clr_cnt_next;
            done_reg       <= done_next;
            class_size_reg <= class_size_next;
            used_cnt_reg   <= used_cnt_next;
            scan_pos_reg   <= scan_pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg     <= in_next;
        pool_reg   <= pool_next;
        pos_reg    <= pos_next;
        cursor_reg <= cursor_next;
        off_reg    <= off_next;
        first_reg  <= first_next;
        nread_reg  <= nread_next;
        result_reg <= result_next;
    end

    assign sts.clear_last  = (clr_cnt_reg == AW'(DEPTH - 1));
    assign sts.is_free     = (in_reg.action == scbca_pkg::ACT_FREE);
    assign sts.decode_done = sts.is_free ? !free_ok : !sel_found;
    assign sts.full        = pool_full;
    assign sts.scan_done   = hit || give_up;

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== hdl/size_class_bitmap_cell_allocator.sv =====
`timescale 1ns / 1ps

// Pool allocator for fixed-size cells. A command is taken when start is high
// and busy is low; its one result shows on result for a single cycle with done
// high and cannot be held off, so the receiver must take it then. After reset
// the used-bit memory, NUM_POOLS rows of 2**max(1, clog2(CELLS_PER_POOL)-3)
// bytes (640 at the defaults), is swept to zero one byte per cycle with busy
// high; class size writes are taken during the sweep. done rises out of the
// decode state for a too-large request or an out-of-range free, out of the
// start state for a full pool, after a map read and write for a free, and for
// an allocation after the start read and an evaluation, plus a read and an
// evaluation per used byte its scan over the byte-wide map port passes before
// finding a free cell. busy drops as done rises, so commands do not overlap.
module size_class_bitmap_cell_allocator #(
    parameter int NUM_POOLS      = 5,
    parameter int CELLS_PER_POOL = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  scbca_pkg::scbca_in_t                req,
    output logic                                done,
    output scbca_pkg::scbca_out_t               result,
    input  logic                                cfg_we,
    input  logic [scbca_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [scbca_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    scbca_pkg::scbca_cmd_t cmd;
    scbca_pkg::scbca_sts_t sts;

    scbca_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    scbca_datapath #(
        .NUM_POOLS      (NUM_POOLS),
        .CELLS_PER_POOL (CELLS_PER_POOL)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .result    (result)
    );

endmodule

// ===== hdl/scbca_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scbca_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   done,
    input scbca_pkg::scbca_out_t  result
);

    // a taken transaction keeps the block busy for at least the next cycle
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, start && !busy, busy)

    // one result per transaction: strobes never come back to back
    `ASSERT_NEXT(a_single_strobe, clk, rst_n, done, !done)

    `ASSERT_SAME(a_status_code, clk, rst_n, done,
        result.status == scbca_pkg::ST_ALLOCATED ||
        result.status == scbca_pkg::ST_TOO_LARGE ||
        result.status == scbca_pkg::ST_EXHAUSTED ||
        result.status == scbca_pkg::ST_FREED ||
        result.status == scbca_pkg::ST_NOT_POOLED)

    // only grants carry a cell, and only grants or exhaustion results carry a pool
    `ASSERT_SAME(a_zero_fields, clk, rst_n,
        done && result.status != scbca_pkg::ST_ALLOCATED,
        result.cell_id == '0 &&
        (result.status == scbca_pkg::ST_EXHAUSTED || result.pool_id == '0))

endmodule

bind size_class_bitmap_cell_allocator scbca_checker u_scbca_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int NUM_POOLS = 5;
    localparam int CELLS     = 1024;
    localparam int MAX_GAP   = 17;
    localparam int IN_W      = $bits(scbca_pkg::scbca_in_t);

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    scbca_pkg::scbca_in_t  req;
    logic       done;
    scbca_pkg::scbca_out_t result;
    logic       cfg_we;
    logic [scbca_pkg::CFG_IDX_W-1:0]  cfg_addr;
    logic [scbca_pkg::CFG_DATA_W-1:0] cfg_wdata;

    // allocator mirror
    logic [scbca_pkg::CFG_DATA_W-1:0] size_of [scbca_pkg::NUM_REGS];
    bit                    cell_taken [NUM_POOLS][CELLS];
    int                    next_fit [NUM_POOLS];
    int                    taken_count [NUM_POOLS];

    scbca_pkg::scbca_out_t pending_outcomes [$];
    int         errors;
    int         results_seen;
    int         seen_by_status [8];
    int         size_settings;
    bit         no_idle;

    size_class_bitmap_cell_allocator #(
        .NUM_POOLS      (NUM_POOLS),
        .CELLS_PER_POOL (CELLS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #16_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // Works out the outcome of one accepted transaction and updates the mirror.
    function automatic scbca_pkg::scbca_out_t expected_outcome(
        input scbca_pkg::scbca_in_t cmd);
        scbca_pkg::scbca_out_t o;
        int         p;
        int         pos;
        int         n;
        o = '0;
        if (cmd.action == scbca_pkg::ACT_ALLOC)
        begin
            p = 0;
            while (p < NUM_POOLS && cmd.request_size > size_of[p])
                p++;
            if (p == NUM_POOLS)
                o.status = scbca_pkg::ST_TOO_LARGE;
            else
            begin
                o.pool_id = p[scbca_pkg::POOL_ID_W-1:0];
                pos = next_fit[p];
                n = 0;
                if (taken_count[p] < CELLS)
                    while (n < CELLS && cell_taken[p][pos])
                    begin
                        pos = (pos + 1) % CELLS;
                        n++;
                    end
                if (taken_count[p] >= CELLS || n == CELLS)
                    o.status = scbca_pkg::ST_EXHAUSTED;
                else
                begin
                    cell_taken[p][pos] = 1'b1;
                    taken_count[p]++;
                    next_fit[p] = pos;
                    o.status  = scbca_pkg::ST_ALLOCATED;
                    o.cell_id = pos[scbca_pkg::CELL_W-1:0];
                end
            end
        end
        else if (cmd.free_pool >= NUM_POOLS)
            o.status = scbca_pkg::ST_NOT_POOLED;
        else
        begin
            // freeing a cell that is already free changes nothing
            if (cell_taken[cmd.free_pool][cmd.free_cell])
            begin
                cell_taken[cmd.free_pool][cmd.free_cell] = 1'b0;
                if (taken_count[cmd.free_pool] > 0)
                    taken_count[cmd.free_pool]--;
            end
            o.status = scbca_pkg::ST_FREED;
        end
        return o;
    endfunction

    function automatic scbca_pkg::scbca_in_t alloc_cmd(input int bytes);
        scbca_pkg::scbca_in_t cmd;
        cmd = IN_W'($urandom);
        cmd.action       = scbca_pkg::ACT_ALLOC;
        cmd.request_size = bytes[scbca_pkg::REQ_W-1:0];
        return cmd;
    endfunction

    function automatic scbca_pkg::scbca_in_t free_cmd(input int pool, input int cell_idx);
        scbca_pkg::scbca_in_t cmd;
        cmd = IN_W'($urandom);
        cmd.action    = scbca_pkg::ACT_FREE;
        cmd.free_pool = pool[scbca_pkg::POOL_ID_W-1:0];
        cmd.free_cell = cell_idx[scbca_pkg::CELL_W-1:0];
        return cmd;
    endfunction

    // Picks a cell that the mirror holds as used, from a random starting point.
    function automatic bit find_taken_cell(output int pool, output int cell_idx);
        int p0;
        int c0;
        p0 = $urandom_range(0, NUM_POOLS - 1);
        pool = 0;
        cell_idx = 0;
        for (int dp = 0; dp < NUM_POOLS; dp++)
        begin
            pool = (p0 + dp) % NUM_POOLS;
            if (taken_count[pool] == 0)
                continue;
            c0 = $urandom_range(0, CELLS - 1);
            for (int dc = 0; dc < CELLS; dc++)
            begin
                cell_idx = (c0 + dc) % CELLS;
                if (cell_taken[pool][cell_idx])
                    return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Drives one transaction and returns at the edge that accepts it.
    task automatic send_cmd(input scbca_pkg::scbca_in_t cmd);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        req   <= cmd;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        pending_outcomes.push_back(expected_outcome(cmd));
    endtask

    task automatic drain_pending();
        @(negedge clk);
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_class_size(input int idx, input int val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx[scbca_pkg::CFG_IDX_W-1:0];
        cfg_wdata <= val[scbca_pkg::CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx < scbca_pkg::NUM_REGS)
            size_of[idx] = val[scbca_pkg::CFG_DATA_W-1:0];
    endtask

    task automatic program_sizes(
        input logic [scbca_pkg::CFG_DATA_W-1:0] sizes [scbca_pkg::NUM_REGS]);
        drain_pending();
        for (int i = 0; i < scbca_pkg::NUM_REGS; i++)
            write_class_size(i, int'(sizes[i]));
        size_settings++;
    endtask

    always @(posedge clk)
    begin
        scbca_pkg::scbca_out_t exp_out;
        if (rst_n && done === 1'b1)
        begin
            results_seen++;
            seen_by_status[result.status]++;
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, result);
                errors++;
            end
            else
            begin
                exp_out = pending_outcomes.pop_front();
                if (result.status !== exp_out.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_out.status, result.status);
                    errors++;
                end
                if (result.pool_id !== exp_out.pool_id)
                begin
                    $display("%0t: pool_id expected %0d actual %0d",
                             $time, exp_out.pool_id, result.pool_id);
                    errors++;
                end
                if (result.cell_id !== exp_out.cell_id)
                begin
                    $display("%0t: cell_id expected %0d actual %0d",
                             $time, exp_out.cell_id, result.cell_id);
                    errors++;
                end
            end
        end
    end

    // Default classes: pool choice at class boundaries and oversize requests.
    task automatic test_size_classes();
        send_cmd(alloc_cmd(0));
        send_cmd(alloc_cmd(16));
        send_cmd(alloc_cmd(17));
        send_cmd(alloc_cmd(32));
        send_cmd(alloc_cmd(33));
        send_cmd(alloc_cmd(64));
        send_cmd(alloc_cmd(128));
        send_cmd(alloc_cmd(256));
        send_cmd(alloc_cmd(257));
        send_cmd(alloc_cmd(65535));
    endtask

    task automatic test_free_paths();
        send_cmd(free_cmd(1, 0));
        send_cmd(free_cmd(1, 0));           // already free
        send_cmd(free_cmd(5, CELLS - 1));
        send_cmd(free_cmd(6, 0));
        send_cmd(free_cmd(7, CELLS - 1));
        send_cmd(free_cmd(4, CELLS - 1));   // never used
        // scan position rests on the granted cell, so a freed grant comes back
        send_cmd(alloc_cmd(100));
        send_cmd(free_cmd(3, 1));
        send_cmd(alloc_cmd(100));
    endtask

    task automatic test_config_extremes();
        program_sizes('{13'd0, 13'd1, 13'd8191, 13'd4096, 13'd2});
        // indexes past the last class are ignored
        for (int idx = scbca_pkg::NUM_REGS; idx < (1 << scbca_pkg::CFG_IDX_W); idx++)
            write_class_size(idx, $urandom_range(0, (1 << scbca_pkg::CFG_DATA_W) - 1));
        send_cmd(alloc_cmd(0));
        send_cmd(alloc_cmd(1));
        send_cmd(alloc_cmd(2));
        send_cmd(alloc_cmd(8191));
        send_cmd(alloc_cmd(8192));
    endtask

    task automatic test_pool_exhaustion();
        program_sizes('{13'd64, 13'd4096, 13'd4096, 13'd4096, 13'd4096});
        while (taken_count[0] < CELLS)
        begin
            if ($urandom_range(0, 99) == 0)
                no_idle = !no_idle;
            send_cmd(alloc_cmd($urandom_range(0, 64)));
        end
        no_idle = 1'b0;
        send_cmd(alloc_cmd(10));            // full pool, no spill to the next one
        send_cmd(alloc_cmd(65));
        send_cmd(free_cmd(0, 700));
        send_cmd(free_cmd(0, 3));
        send_cmd(alloc_cmd(1));             // wraps from the top of the pool
        send_cmd(alloc_cmd(1));
        send_cmd(alloc_cmd(1));
        // leave scattered holes for long scans later
        repeat (40)
            send_cmd(free_cmd(0, $urandom_range(0, CELLS - 1)));
    endtask

    task automatic run_traffic(input int n_items);
        int        roll;
        int        p;
        int        c;
        scbca_pkg::scbca_in_t cmd;
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                no_idle = !no_idle;
            if ($urandom_range(0, 79) == 0)
                drain_pending();
            roll = $urandom_range(0, 99);
            if (roll < 55)
            begin
                p = $urandom_range(0, NUM_POOLS - 1);
                cmd = alloc_cmd($urandom_range(0, size_of[p]));
            end
            else if (roll < 85 && find_taken_cell(p, c))
                cmd = free_cmd(p, c);
            else if (roll < 93)
                cmd = alloc_cmd($urandom_range(0, (1 << scbca_pkg::REQ_W) - 1));
            else
                cmd = free_cmd($urandom_range(0, (1 << scbca_pkg::POOL_ID_W) - 1),
                               $urandom_range(0, CELLS - 1));
            send_cmd(cmd);
        end
    endtask

    task automatic test_random_traffic();
        logic [scbca_pkg::CFG_DATA_W-1:0] sizes [scbca_pkg::NUM_REGS];
        program_sizes(scbca_pkg::CLASS_SIZE_RESET);
        run_traffic(20);
        program_sizes('{13'd1, 13'd4096, 13'd1, 13'd4096, 13'd4096});
        run_traffic(20);
        foreach (sizes[i])
            sizes[i] = scbca_pkg::CFG_DATA_W'($urandom_range(1, 4096));
        program_sizes(sizes);
        write_class_size(scbca_pkg::NUM_REGS, $urandom_range(1, 4096));
        run_traffic(20);
        program_sizes('{13'd4096, 13'd8191, 13'd0, 13'd1, 13'd4096});
        run_traffic(20);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        no_idle   = 1'b0;
        foreach (size_of[i])
            size_of[i] = scbca_pkg::CLASS_SIZE_RESET[i];
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        // map clear runs after reset with busy high
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);

        test_size_classes();
        test_free_paths();
        test_config_extremes();
        test_pool_exhaustion();
        test_random_traffic();

        drain_pending();
        repeat (300) @(posedge clk);
        $display("Covered %0d transactions under %0d class size settings.",
                 results_seen, size_settings);
        $display("allocated %0d, too large %0d, exhausted %0d, freed %0d, not pooled %0d",
                 seen_by_status[scbca_pkg::ST_ALLOCATED],
                 seen_by_status[scbca_pkg::ST_TOO_LARGE],
                 seen_by_status[scbca_pkg::ST_EXHAUSTED],
                 seen_by_status[scbca_pkg::ST_FREED],
                 seen_by_status[scbca_pkg::ST_NOT_POOLED]);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
